FILE: rtl/core/bdr_pkg.sv
// Shared types and codes for the bounded deque with reverse.
// Used by the top level, the storage cell and the port checker.
package bdr_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4,
        OP_REVERSE    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_RANGE = 2'd3
    } status_t;

    // per-cell control, shared by every cell of the row
    typedef struct packed {
        logic load;         // write the pushed word here
        logic shift_right;  // take the left neighbor's word
        logic shift_left;   // take the right neighbor's word
    } cell_ctl_t;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 4;

endpackage

FILE: rtl/core/bdr_cell.sv
// One storage cell of the deque row: holds a word and trades it with its neighbors.
// Depends on bdr_pkg for the cell control struct.
module bdr_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   aclk,
    input  bdr_pkg::cell_ctl_t     ctl,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic [DATA_WIDTH-1:0]  right_data,
    input  logic [DATA_WIDTH-1:0]  push_word,
    output logic [DATA_WIDTH-1:0]  q
);

    logic [DATA_WIDTH-1:0] q_reg;
    logic [DATA_WIDTH-1:0] q_next;

    always_comb begin
        priority if (ctl.load) begin
            q_next = push_word;
        end else if (ctl.shift_right) begin
            q_next = left_data;
        end else if (ctl.shift_left) begin
            q_next = right_data;
        end else begin
            q_next = q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

FILE: rtl/core/bounded_deque_with_reverse_top.sv
// Top level of the bounded deque with reverse: control, row of cells, result register.
// Depends on bdr_pkg and bdr_cell.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tuser: operation; tdata: value, position
//  m_      | out | m_tvalid/m_tready  | tuser: status;    tdata: data, occupancy
//
// One word per cycle while m_ is not stalled: each word is decoded, the cell row shifts or loads in that
// cycle, and the result is written into the output register at the accepting edge,
// so it is offered on m_ in the next cycle.
// The single read port on the cell row sets the path: index math, then one mux.
// Reset (aresetn low, synchronous) empties the deque and restores normal order.
// s_tready stays high while the output register is empty or being drained.
module bounded_deque_with_reverse_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] value, [35:32] position, [39:36] zero
    input  logic [bdr_pkg::IN_DATA_W-1:0]    s_tdata,
    // [2:0] operation
    input  logic [bdr_pkg::OP_W-1:0]         s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] data, [36:32] occupancy, [39:37] zero
    output logic [bdr_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic [bdr_pkg::STATUS_W-1:0]     m_tuser
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > bdr_pkg::POS_W) ? CNT_W : bdr_pkg::POS_W;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rev_reg, rev_next;
    logic              m_valid_reg;
    logic [bdr_pkg::WORD_W-1:0] out_data_reg;
    logic [bdr_pkg::OCC_W-1:0]  out_occ_reg;
    bdr_pkg::status_t  out_status_reg;

    bdr_pkg::op_t      op;
    bdr_pkg::status_t  status;
    logic              accept;
    logic              full, empty, pos_ok;
    logic              push_tail, push_head, pop_head, rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [CMP_W-1:0]  pos_ext, cnt_ext, rev_pos;
    logic [DATA_WIDTH-1:0] push_word;
    logic [DATA_WIDTH-1:0] cell_q [DEPTH];
    logic [63:0]       value_wide, rd_wide;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = ~m_valid_reg | m_tready;
    assign op       = bdr_pkg::op_t'(s_tuser);

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(s_tdata[35:32]);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ok  = (pos_ext < cnt_ext);
    assign rev_pos = cnt_ext - CMP_W'(1) - pos_ext;

    assign value_wide = 64'(s_tdata[31:0]);
    assign push_word  = value_wide[DATA_WIDTH-1:0];

    always_comb begin
        count_next = count_reg;
        rev_next   = rev_reg;
        status     = bdr_pkg::STATUS_OK;
        push_tail  = 1'b0;
        push_head  = 1'b0;
        pop_head   = 1'b0;
        rd_en      = 1'b0;
        rd_idx     = '0;
        unique case (op)
            bdr_pkg::OP_PUSH_BACK, bdr_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    status = bdr_pkg::STATUS_FULL;
                end else begin
                    // reversed order swaps which physical end a push lands on
                    if ((op == bdr_pkg::OP_PUSH_BACK) != rev_reg) begin
                        push_tail = 1'b1;
                    end else begin
                        push_head = 1'b1;
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            bdr_pkg::OP_POP_FRONT, bdr_pkg::OP_POP_BACK: begin
                if (empty) begin
                    status = bdr_pkg::STATUS_EMPTY;
                end else begin
                    rd_en = 1'b1;
                    if ((op == bdr_pkg::OP_POP_FRONT) != rev_reg) begin
                        pop_head = 1'b1;
                    end else begin
                        rd_idx = IDX_W'(count_reg - CNT_W'(1));
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            bdr_pkg::OP_READ: begin
                if (!pos_ok) begin
                    status = bdr_pkg::STATUS_RANGE;
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = rev_reg ? IDX_W'(rev_pos) : IDX_W'(pos_ext);
                end
            end
            bdr_pkg::OP_REVERSE: begin
                rev_next = ~rev_reg;
            end
            default: begin
            end
        endcase
    end

    // row of cells: physical front is cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        bdr_pkg::cell_ctl_t    ctl;
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        // load, shift_right, shift_left
        assign ctl = {accept & push_tail & (count_reg == CNT_W'(i)),
                      accept & push_head,
                      accept & pop_head};

        if (i == 0) begin : g_head
            assign left_data = push_word;
        end else begin : g_mid
            assign left_data = cell_q[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_data = cell_q[i];
        end else begin : g_body
            assign right_data = cell_q[i+1];
        end

        bdr_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .left_data  (left_data),
            .right_data (right_data),
            .push_word  (push_word),
            .q          (cell_q[i])
        );
    end

    assign rd_wide = 64'(cell_q[rd_idx]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                rev_reg     <= rev_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg   <= rd_en ? rd_wide[bdr_pkg::WORD_W-1:0] : '0;
            out_occ_reg    <= bdr_pkg::OCC_W'(count_next);
            out_status_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_occ_reg, out_data_reg};
    assign m_tuser  = out_status_reg;

endmodule

FILE: rtl/core/bdr_checker.sv
// Port-level checker for the bounded deque with reverse, bound to the top level.
// Depends on bdr_pkg for the status codes.
module bdr_checker #(
    parameter int DEPTH = 16
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bdr_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [bdr_pkg::STATUS_W-1:0]    m_tuser
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == bdr_pkg::STATUS_FULL |-> m_tdata[36:32] == 5'(DEPTH))
        else $error("full status without full occupancy");

    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == bdr_pkg::STATUS_EMPTY |-> m_tdata[36:32] == 5'd0
            && m_tdata[31:0] == 32'd0)
        else $error("empty status with words stored or data");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (DEPTH > 31) || (m_tdata[36:32] <= 5'(DEPTH)))
        else $error("occupancy beyond depth");

endmodule

bind bounded_deque_with_reverse_top bdr_checker #(
    .DEPTH(DEPTH)
) u_bdr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
